// ===== design/tsa_pkg.sv =====
// tetrahedron surface area: shared widths
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package tsa_pkg;
  localparam int unsigned RootBits = 30;
  localparam int unsigned RadBits  = 60;
  localparam int unsigned AreaBits = 31;
  localparam int unsigned SumBits  = 32;
endpackage
`default_nettype wire

// ===== design/tsa_face.sv =====
// one face: edge vectors, cross product, squares and their sum over four registered stages
// depends on tsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module tsa_face import tsa_pkg::*; #(
  parameter int unsigned CoordBits = 12
) (
  input  wire logic                       clk_i,
  input  wire logic signed [CoordBits-1:0] p_i [3],
  input  wire logic signed [CoordBits-1:0] q_i [3],
  input  wire logic signed [CoordBits-1:0] r_i [3],
  output logic         [RadBits-1:0]      rad_o
);
  localparam int unsigned EW = CoordBits + 1;
  localparam int unsigned CW = 2 * EW + 1;
  localparam int unsigned MW = CW - 1;
  logic signed [EW-1:0] u_q [3];
  logic signed [EW-1:0] v_q [3];
  logic signed [CW-1:0] ue [3];
  logic signed [CW-1:0] ve [3];
  logic signed [CW-1:0] c_q [3];
  logic [MW-1:0]        m_w [3];
  logic [2*MW-1:0]      p_w [3];
  logic [RadBits-1:0]   sq_q [3];
  logic [RadBits-1:0]   rad_q;

  // edge vectors widened before the products, magnitudes before the squares
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ue[i]  = CW'(u_q[i]);
      ve[i]  = CW'(v_q[i]);
      m_w[i] = c_q[i][CW-1] ? MW'(-c_q[i]) : MW'(c_q[i]);
      p_w[i] = m_w[i] * m_w[i];
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      u_q[i] <= EW'(q_i[i]) - EW'(p_i[i]);
      v_q[i] <= EW'(r_i[i]) - EW'(p_i[i]);
    end
    c_q[0] <= ue[1] * ve[2] - ve[1] * ue[2];
    c_q[1] <= ue[0] * ve[2] - ve[0] * ue[2];
    c_q[2] <= ue[0] * ve[1] - ve[0] * ue[1];
    for (int i = 0; i < 3; i++) begin
      sq_q[i] <= RadBits'(p_w[i]);
    end
    rad_q <= sq_q[0] + sq_q[1] + sq_q[2];
  end
  assign rad_o = rad_q;
endmodule
`default_nettype wire

// ===== design/tsa_sqrt_cell.sv =====
// one cell of the root chain: settles one result bit and hands on
// depends on tsa_pkg
`timescale 1ns / 1ps
`default_nettype none
module tsa_sqrt_cell import tsa_pkg::*; #(
  parameter int unsigned Step = 0
) (
  input  wire logic                 clk_i,
  input  wire logic [RadBits+7:0]   x_i,
  input  wire logic [RadBits+7:0]   res_i,
  output logic      [RadBits+7:0]   x_o,
  output logic      [RadBits+7:0]   res_o
);
  localparam int unsigned W = RadBits + 8;
  localparam logic [W-1:0] Bit = W'(1) << (2 * (33 - Step));
  logic [W-1:0] t;
  logic [W-1:0] x_q, res_q;
  assign t = res_i + Bit;
  always_ff @(posedge clk_i) begin
    if (x_i >= t) begin
      x_q   <= x_i - t;
      res_q <= (res_i >> 1) + Bit;
    end else begin
      x_q   <= x_i;
      res_q <= res_i >> 1;
    end
  end
  assign x_o = x_q;
  assign res_o = res_q;
endmodule
`default_nettype wire

// ===== design/tsa_root.sv =====
// chain of root cells, one bit per cell
// depends on tsa_pkg, tsa_sqrt_cell
`timescale 1ns / 1ps
`default_nettype none
module tsa_root import tsa_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic [RadBits-1:0] rad_i,
  output logic      [RootBits-1:0] root_o
);
  localparam int unsigned W = RadBits + 8;
  localparam int unsigned Cells = 34;
  logic [W-1:0] x_w [Cells+1];
  logic [W-1:0] r_w [Cells+1];
  assign x_w[0] = {rad_i, 8'd0};
  assign r_w[0] = '0;
  for (genvar g = 0; g < Cells; g++) begin : g_cell
    tsa_sqrt_cell #(.Step(g)) u_cell (
      .clk_i, .x_i(x_w[g]), .res_i(r_w[g]), .x_o(x_w[g+1]), .res_o(r_w[g+1]));
  end
  assign root_o = r_w[Cells][RootBits-1:0];
endmodule
`default_nettype wire

// ===== design/tetrahedron_surface_area.sv =====
// top level: four face units, four root chains, summing stages
// depends on tsa_pkg, tsa_face, tsa_root
`timescale 1ns / 1ps
`default_nettype none
// one tetrahedron accepted every cycle (busy is always low); the area
// appears on area_q4_o with done_o high after 3 face stages, 1 radicand
// register, 34 root cells (one bit each) and 2 summing stages.
// the receiver cannot stall, every result shows for exactly one cycle
module tetrahedron_surface_area import tsa_pkg::*; #(
  parameter int unsigned COORD_BITS = 12
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [11:0] ax_i, ay_i, az_i, bx_i, by_coord_i, bz_i,
  input  wire logic signed [11:0] cx_i, cy_i, cz_i, dx_i, dy_i, dz_i,
  output logic                    done_o,
  output logic [AreaBits-1:0]     area_q4_o
);
  localparam int unsigned Lat = 40;
  logic signed [COORD_BITS-1:0] a [3], b [3], c [3], d [3];
  logic [RadBits-1:0]  rad_w [4];
  logic [RootBits-1:0] root_w [4];
  logic [SumBits-1:0]  pair_q [2];
  logic [AreaBits-1:0] area_q;
  logic [Lat-1:0]      vld_q;

  assign busy = 1'b0;
  // only the low coordinate bits count, sign taken from the top one kept
  assign a = '{ax_i[COORD_BITS-1:0], ay_i[COORD_BITS-1:0], az_i[COORD_BITS-1:0]};
  assign b = '{bx_i[COORD_BITS-1:0], by_coord_i[COORD_BITS-1:0], bz_i[COORD_BITS-1:0]};
  assign c = '{cx_i[COORD_BITS-1:0], cy_i[COORD_BITS-1:0], cz_i[COORD_BITS-1:0]};
  assign d = '{dx_i[COORD_BITS-1:0], dy_i[COORD_BITS-1:0], dz_i[COORD_BITS-1:0]};

  tsa_face #(.CoordBits(COORD_BITS)) u_abc (.clk_i, .p_i(a), .q_i(b), .r_i(c), .rad_o(rad_w[0]));
  tsa_face #(.CoordBits(COORD_BITS)) u_abd (.clk_i, .p_i(a), .q_i(b), .r_i(d), .rad_o(rad_w[1]));
  tsa_face #(.CoordBits(COORD_BITS)) u_acd (.clk_i, .p_i(a), .q_i(c), .r_i(d), .rad_o(rad_w[2]));
  tsa_face #(.CoordBits(COORD_BITS)) u_bcd (.clk_i, .p_i(b), .q_i(c), .r_i(d), .rad_o(rad_w[3]));

  for (genvar f = 0; f < 4; f++) begin : g_root
    tsa_root u_root (.clk_i, .rad_i(rad_w[f]), .root_o(root_w[f]));
  end

  // roots summed, halved as each is twice a face area; four fraction bits
  always_ff @(posedge clk_i) begin
    pair_q[0] <= SumBits'(root_w[0]) + SumBits'(root_w[1]);
    pair_q[1] <= SumBits'(root_w[2]) + SumBits'(root_w[3]);
    area_q    <= AreaBits'((pair_q[0] + pair_q[1]) >> 1);
  end

  // valid marks travel alongside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[Lat-2:0], start};
    end
  end

  assign done_o    = vld_q[Lat-1];
  assign area_q4_o = area_q;
endmodule
`default_nettype wire

// ===== design/tsa_checker.sv =====
// port-level checks for the surface area block, bound to the top level
// depends on tetrahedron_surface_area ports
`timescale 1ns / 1ps
`default_nettype none
module tsa_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done_o,
  input wire logic [30:0] area_q4_o
);
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy)
    else $error("busy raised");
  a_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start ##40 1'b1 |-> done_o) else $error("result missing");
  a_no_spur: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 40)) else $error("spurious result");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(start, 40) && $past(1'b1, 40) |-> area_q4_o[30] == 1'b0)
    else $error("area out of range");
endmodule
bind tetrahedron_surface_area tsa_checker u_tsa_checker (.*);
`default_nettype wire
